### hdl/gap_buffer_text_store_macros.svh
// Assertion macros for the gap buffer text store RTL.
// Included by gap_buffer_text_store, which carries concurrent checks; no other dependencies.
`ifndef GAP_BUFFER_TEXT_STORE_MACROS_SVH
`define GAP_BUFFER_TEXT_STORE_MACROS_SVH

// Condition must hold on every clock edge outside reset.
`define GBTS_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define GBTS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GBTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/gbts_pkg.sv
// Shared types, codes and helpers for the gap buffer text store.
// No dependencies; used by gbts_store and gap_buffer_text_store.
package gbts_pkg;

  localparam int unsigned KIND_W = 2;
  localparam int unsigned POS_W  = 13;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned STAT_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_READ   = 2'd2,
    KIND_NOP    = 2'd3
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Byte store operations.
  typedef enum logic [1:0] {
    OP_COPY_UP   = 2'd0,
    OP_COPY_DOWN = 2'd1,
    OP_READ      = 2'd2,
    OP_WRITE     = 2'd3
  } store_op_e;

  typedef struct packed {
    logic      valid;
    store_op_e op;
  } store_cmd_t;

  // UTF-8 lead byte decode.
  localparam logic [CHAR_W-1:0] U8_ASCII_MASK = 8'h80;
  localparam logic [CHAR_W-1:0] U8_MASK2      = 8'hE0;
  localparam logic [CHAR_W-1:0] U8_LEAD2      = 8'hC0;
  localparam logic [CHAR_W-1:0] U8_MASK3      = 8'hF0;
  localparam logic [CHAR_W-1:0] U8_LEAD3      = 8'hE0;
  localparam logic [CHAR_W-1:0] U8_MASK4      = 8'hF8;
  localparam logic [CHAR_W-1:0] U8_LEAD4      = 8'hF0;

  function automatic logic [2:0] utf8_len(logic [CHAR_W-1:0] b);
    logic [2:0] len;
    if ((b & U8_ASCII_MASK) == '0) len = 3'd1;
    else if ((b & U8_MASK2) == U8_LEAD2) len = 3'd2;
    else if ((b & U8_MASK3) == U8_LEAD3) len = 3'd3;
    else if ((b & U8_MASK4) == U8_LEAD4) len = 3'd4;
    else len = 3'd1;
    return len;
  endfunction

endpackage

### hdl/gap_buffer_text_store.sv
// Gap buffer text store: insert byte, delete UTF-8 codepoint, read byte.
// Insert and delete first move the gap to the position, copying the bytes it passes when it
// is open; an insert that finds the gap closed reopens it by shifting the tail up by GAP_GROW.
// One item at a time: in_ready_o goes high in the same cycle a result is presented on out_valid_o.
// Copies move one byte per cycle; a result not yet taken holds the block in S_DONE.
// Reset zeroes gap start and text count, sets gap end to GAP_GROW; store contents undefined.
module gap_buffer_text_store #(
  parameter int unsigned CAPACITY = 4096,
  parameter int unsigned GAP_GROW = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [gbts_pkg::KIND_W-1:0] kind_i,
  input  logic [gbts_pkg::POS_W-1:0]  position_i,
  input  logic [gbts_pkg::CHAR_W-1:0] char_in_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [gbts_pkg::POS_W-1:0]  new_position_o,
  output logic [gbts_pkg::CHAR_W-1:0] read_byte_o,
  output logic [gbts_pkg::STAT_W-1:0] status_o,
  output logic [gbts_pkg::POS_W-1:0]  text_length_o
);
  import gbts_pkg::*;

  `include "gap_buffer_text_store_macros.svh"

  localparam int unsigned AW  = $clog2(CAPACITY);
  localparam int unsigned CW  = (AW + 1 > POS_W) ? AW + 1 : POS_W;
  localparam logic [CW:0] FULL_LIMIT = (CW + 1)'(CAPACITY);
  localparam logic [CW-1:0] GROW = CW'(GAP_GROW);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_MOVE, S_POST, S_SHIFT, S_INS, S_LEAD, S_RDWAIT, S_DONE
  } state_e;

  state_e state_q, state_d;

  logic [CW-1:0] gs_q, gs_d;
  logic [CW-1:0] ge_q, ge_d;
  logic [CW-1:0] cnt_q, cnt_d;

  kind_e             kind_q, kind_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [CHAR_W-1:0] ch_q, ch_d;
  status_e           stat_q, stat_d;
  logic [CHAR_W-1:0] rd_q, rd_d;
  logic [POS_W-1:0]  npos_q, npos_d;

  logic              out_valid_q, out_valid_d;
  logic [POS_W-1:0]  o_npos_q, o_npos_d;
  logic [CHAR_W-1:0] o_rd_q, o_rd_d;
  logic [STAT_W-1:0] o_stat_q, o_stat_d;
  logic [POS_W-1:0]  o_len_q, o_len_d;

  store_cmd_t        cmd;
  logic [CW-1:0]     st_src, st_dst, st_len;
  logic [CHAR_W-1:0] st_rdata;
  logic              st_busy;

  logic [CW-1:0] pos_ext;
  logic [CW-1:0] gap_size;
  logic [CW-1:0] tail;
  logic [CW-1:0] rest;
  logic [CW-1:0] del_len;
  logic          full;
  logic          start_move;

  assign pos_ext  = CW'(pos_q);
  assign gap_size = ge_q - gs_q;
  assign tail     = cnt_q - gs_q;
  assign rest     = cnt_q - gs_q;
  assign full     = ({1'b0, cnt_q} + {1'b0, GROW}) >= FULL_LIMIT;

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign new_position_o = o_npos_q;
  assign read_byte_o    = o_rd_q;
  assign status_o       = o_stat_q;
  assign text_length_o  = o_len_q;

  gbts_store #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .src_i   (st_src),
    .dst_i   (st_dst),
    .len_i   (st_len),
    .wdata_i (ch_q),
    .rdata_o (st_rdata),
    .busy_o  (st_busy)
  );

  always_comb begin
    state_d     = state_q;
    gs_d        = gs_q;
    ge_d        = ge_q;
    cnt_d       = cnt_q;
    kind_d      = kind_q;
    pos_d       = pos_q;
    ch_d        = ch_q;
    stat_d      = stat_q;
    rd_d        = rd_q;
    npos_d      = npos_q;
    out_valid_d = out_valid_q && !out_ready_i;
    o_npos_d    = o_npos_q;
    o_rd_d      = o_rd_q;
    o_stat_d    = o_stat_q;
    o_len_d     = o_len_q;
    cmd         = '{valid: 1'b0, op: OP_READ};
    st_src      = '0;
    st_dst      = '0;
    st_len      = '0;
    start_move  = 1'b0;
    del_len     = CW'(utf8_len(st_rdata));

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          kind_d  = kind_e'(kind_i);
          pos_d   = position_i;
          ch_d    = char_in_i;
          stat_d  = ST_DONE;
          rd_d    = '0;
          npos_d  = position_i;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        case (kind_q)
          KIND_INSERT: begin
            if (full) begin
              stat_d  = ST_FULL;
              state_d = S_DONE;
            end else if (pos_ext > cnt_q) begin
              stat_d  = ST_RANGE;
              state_d = S_DONE;
            end else begin
              start_move = 1'b1;
            end
          end
          KIND_DELETE: begin
            if (pos_ext >= cnt_q) begin
              stat_d  = ST_RANGE;
              state_d = S_DONE;
            end else begin
              start_move = 1'b1;
            end
          end
          KIND_READ: begin
            if (pos_ext >= cnt_q) begin
              stat_d  = ST_RANGE;
              state_d = S_DONE;
            end else begin
              cmd    = '{valid: 1'b1, op: OP_READ};
              st_src = (pos_ext < gs_q) ? pos_ext : pos_ext - gs_q + ge_q;
              state_d = S_RDWAIT;
            end
          end
          default: state_d = S_DONE;
        endcase
        if (start_move) begin
          // an empty gap just relabels; otherwise copy the bytes it passes
          if (pos_ext < gs_q) begin
            cmd    = '{valid: 1'b1, op: OP_COPY_DOWN};
            st_src = gs_q - 1'b1;
            st_dst = ge_q - 1'b1;
            st_len = (gap_size == '0) ? '0 : gs_q - pos_ext;
          end else begin
            cmd    = '{valid: 1'b1, op: OP_COPY_UP};
            st_src = ge_q;
            st_dst = gs_q;
            st_len = (gap_size == '0) ? '0 : pos_ext - gs_q;
          end
          gs_d    = pos_ext;
          ge_d    = pos_ext + gap_size;
          state_d = S_MOVE;
        end
      end
      S_MOVE: begin
        if (!st_busy) state_d = S_POST;
      end
      S_POST: begin
        if (kind_q == KIND_INSERT) begin
          if (gs_q == ge_q) begin
            // reopen the gap: shift the tail right, last byte first
            cmd     = '{valid: 1'b1, op: OP_COPY_DOWN};
            st_src  = ge_q + tail - 1'b1;
            st_dst  = ge_q + tail - 1'b1 + GROW;
            st_len  = tail;
            ge_d    = ge_q + GROW;
            state_d = S_SHIFT;
          end else begin
            state_d = S_INS;
          end
        end else begin
          cmd     = '{valid: 1'b1, op: OP_READ};
          st_src  = ge_q;
          state_d = S_LEAD;
        end
      end
      S_SHIFT: begin
        if (!st_busy) state_d = S_INS;
      end
      S_INS: begin
        cmd     = '{valid: 1'b1, op: OP_WRITE};
        st_dst  = gs_q;
        gs_d    = gs_q + 1'b1;
        cnt_d   = cnt_q + 1'b1;
        npos_d  = pos_q + 1'b1;
        state_d = S_DONE;
      end
      S_LEAD: begin
        if (del_len > rest) del_len = rest;
        ge_d    = ge_q + del_len;
        cnt_d   = cnt_q - del_len;
        state_d = S_DONE;
      end
      S_RDWAIT: begin
        rd_d    = st_rdata;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          o_npos_d    = npos_q;
          o_rd_d      = rd_q;
          o_stat_d    = stat_q;
          o_len_d     = cnt_q[POS_W-1:0];
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      gs_q        <= '0;
      ge_q        <= GROW;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      gs_q        <= gs_d;
      ge_q        <= ge_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    pos_q    <= pos_d;
    ch_q     <= ch_d;
    stat_q   <= stat_d;
    rd_q     <= rd_d;
    npos_q   <= npos_d;
    o_npos_q <= o_npos_d;
    o_rd_q   <= o_rd_d;
    o_stat_q <= o_stat_d;
    o_len_q  <= o_len_d;
  end

  `GBTS_ASSERT_ALWAYS(a_gap_order, clk_i, rst_ni, ge_q >= gs_q, "gap end below gap start")
  `GBTS_ASSERT_ALWAYS(a_gap_in_text, clk_i, rst_ni, gs_q <= cnt_q, "gap start past text end")
  `GBTS_ASSERT_ALWAYS(a_fits_store, clk_i, rst_ni,
    ({1'b0, cnt_q} + {1'b0, gap_size}) <= FULL_LIMIT, "text and gap exceed the store")
  `GBTS_ASSERT_IMPL(a_busy_in_copy, clk_i, rst_ni, st_busy,
    state_q == S_MOVE || state_q == S_SHIFT, "copy engine busy outside a copy phase")
  `GBTS_ASSERT_NEXT(a_done_delivers, clk_i, rst_ni,
    state_q == S_DONE && (!out_valid_q || out_ready_i),
    out_valid_q && state_q == S_IDLE, "finished item not presented")

endmodule

### hdl/gbts_store.sv
// Byte store of the gap buffer with its block copy engine.
// One read and one write per cycle, registered read data; uses gbts_pkg.
module gbts_store #(
  parameter int unsigned CAPACITY = 4096,
  parameter int unsigned AW       = 12,
  parameter int unsigned CW       = 13
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  gbts_pkg::store_cmd_t       cmd_i,
  input  logic [CW-1:0]              src_i,
  input  logic [CW-1:0]              dst_i,
  input  logic [CW-1:0]              len_i,
  input  logic [gbts_pkg::CHAR_W-1:0] wdata_i,
  output logic [gbts_pkg::CHAR_W-1:0] rdata_o,
  output logic                       busy_o
);
  import gbts_pkg::*;

  logic [CHAR_W-1:0] mem [CAPACITY];
  logic [CHAR_W-1:0] rdata_q;

  logic [AW-1:0] src_q, src_d;
  logic [AW-1:0] dst_q, dst_d;
  logic [CW-1:0] rem_q, rem_d;
  logic          down_q, down_d;
  logic          pend_q, pend_d;
  logic [AW-1:0] pend_dst_q, pend_dst_d;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [CHAR_W-1:0] wr_data;
  logic          step;

  assign step   = (rem_q != '0);
  assign busy_o = step | pend_q;
  assign rdata_o = rdata_q;

  always_comb begin
    src_d      = src_q;
    dst_d      = dst_q;
    rem_d      = rem_q;
    down_d     = down_q;
    pend_d     = 1'b0;
    pend_dst_d = pend_dst_q;
    rd_en      = 1'b0;
    rd_addr    = src_q;
    wr_en      = 1'b0;
    wr_addr    = pend_dst_q;
    wr_data    = rdata_q;

    if (step) begin
      // one byte per cycle: read now, write it back next cycle
      rd_en      = 1'b1;
      pend_d     = 1'b1;
      pend_dst_d = dst_q;
      rem_d      = rem_q - 1'b1;
      src_d      = down_q ? src_q - 1'b1 : src_q + 1'b1;
      dst_d      = down_q ? dst_q - 1'b1 : dst_q + 1'b1;
    end else if (cmd_i.valid) begin
      case (cmd_i.op)
        OP_COPY_UP, OP_COPY_DOWN: begin
          src_d  = src_i[AW-1:0];
          dst_d  = dst_i[AW-1:0];
          rem_d  = len_i;
          down_d = (cmd_i.op == OP_COPY_DOWN);
        end
        OP_READ: begin
          rd_en   = 1'b1;
          rd_addr = src_i[AW-1:0];
        end
        default: ;
      endcase
    end

    if (pend_q) begin
      wr_en = 1'b1;
    end else if (cmd_i.valid && cmd_i.op == OP_WRITE) begin
      wr_en   = 1'b1;
      wr_addr = dst_i[AW-1:0];
      wr_data = wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      pend_q <= 1'b0;
      down_q <= 1'b0;
    end else begin
      rem_q  <= rem_d;
      pend_q <= pend_d;
      down_q <= down_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q      <= src_d;
    dst_q      <= dst_d;
    pend_dst_q <= pend_dst_d;
  end

endmodule

### sim/tb.sv
// Self-checking testbench for gap_buffer_text_store: insert, delete and read items
// are checked against an in-bench gap buffer model. Needs gbts_pkg and the RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gbts_pkg::*;

  localparam int unsigned CAP       = 4096;
  localparam int unsigned GROW      = 16;
  localparam int unsigned RAND_ITEMS = 850;
  localparam int unsigned STALL_LIMIT = 40000;

  typedef struct packed {
    kind_e             kind;
    logic [POS_W-1:0]  pos;
    logic [CHAR_W-1:0] ch;
  } edit_t;

  typedef struct packed {
    logic [POS_W-1:0]  new_pos;
    logic [CHAR_W-1:0] rd;
    status_e           st;
    logic [POS_W-1:0]  len;
  } answer_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [KIND_W-1:0] kind_i = '0;
  logic [POS_W-1:0]  position_i = '0;
  logic [CHAR_W-1:0] char_in_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [POS_W-1:0]  new_position_o;
  logic [CHAR_W-1:0] read_byte_o;
  logic [STAT_W-1:0] status_o;
  logic [POS_W-1:0]  text_length_o;

  logic        calm = 1'b0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;

  edit_t   edit_q[$];
  answer_t answer_q[$];

  // Model of the buffer: byte store, gap [g_lo, g_hi), logical length.
  logic [7:0]  text_mem [0:CAP-1];
  int unsigned g_lo = 0;
  int unsigned g_hi = GROW;
  int unsigned n_text = 0;

  always #10 clk_i = ~clk_i;

  gap_buffer_text_store #(
    .CAPACITY(CAP),
    .GAP_GROW(GROW)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .position_i    (position_i),
    .char_in_i     (char_in_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .new_position_o(new_position_o),
    .read_byte_o   (read_byte_o),
    .status_o      (status_o),
    .text_length_o (text_length_o)
  );

  function automatic logic [7:0] mem_rd(int unsigned i);
    return (i < CAP) ? text_mem[i] : 8'h00;
  endfunction

  function automatic void mem_wr(int unsigned i, logic [7:0] v);
    if (i < CAP) text_mem[i] = v;
  endfunction

  function automatic int unsigned lead_len(logic [7:0] b);
    casez (b)
      8'b0???????: return 1;
      8'b110?????: return 2;
      8'b1110????: return 3;
      8'b11110???: return 4;
      default:     return 1;
    endcase
  endfunction

  function automatic void move_gap(int unsigned pos);
    int unsigned n;
    if (pos == g_lo) return;
    if (g_lo == g_hi) begin
      // empty gap: physical and logical addresses coincide
      g_lo = pos;
      g_hi = pos;
      return;
    end
    if (pos < g_lo) begin
      n = g_lo - pos;
      for (int unsigned k = n; k > 0; k--) mem_wr(g_hi - n + k - 1, mem_rd(pos + k - 1));
      g_lo -= n;
      g_hi -= n;
    end else begin
      n = pos - g_lo;
      for (int unsigned k = 0; k < n; k++) mem_wr(g_lo + k, mem_rd(g_hi + k));
      g_lo += n;
      g_hi += n;
    end
  endfunction

  function automatic void edit_buffer(edit_t e);
    int unsigned p;
    int unsigned cut;
    answer_t     a;
    p = e.pos;
    a.new_pos = e.pos;
    a.rd = '0;
    a.st = ST_DONE;
    case (e.kind)
      KIND_INSERT: begin
        if (n_text + GROW >= CAP) a.st = ST_FULL;
        else if (p > n_text) a.st = ST_RANGE;
        else begin
          move_gap(p);
          if (g_lo == g_hi) begin
            for (int unsigned k = n_text - g_lo; k > 0; k--)
              mem_wr(g_hi + GROW + k - 1, mem_rd(g_hi + k - 1));
            g_hi += GROW;
          end
          mem_wr(g_lo, e.ch);
          g_lo++;
          n_text++;
          a.new_pos = e.pos + 1'b1;
        end
      end
      KIND_DELETE: begin
        if (p >= n_text) a.st = ST_RANGE;
        else begin
          move_gap(p);
          cut = lead_len(mem_rd(g_hi));
          if (cut > n_text - g_lo) cut = n_text - g_lo;
          g_hi += cut;
          n_text -= cut;
        end
      end
      KIND_READ: begin
        if (p >= n_text) a.st = ST_RANGE;
        else a.rd = (p < g_lo) ? mem_rd(p) : mem_rd(p - g_lo + g_hi);
      end
      default: ;
    endcase
    a.len = n_text[POS_W-1:0];
    answer_q.push_back(a);
  endfunction

  task automatic flag_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Byte with a bias toward UTF-8 lead and continuation patterns.
  function automatic logic [7:0] pick_char();
    case ($urandom_range(6))
      0:       return 8'($urandom_range(8'h7f));
      1:       return {3'b110, 5'($urandom)};
      2:       return {4'b1110, 4'($urandom)};
      3:       return {5'b11110, 3'($urandom)};
      4:       return {2'b10, 6'($urandom)};
      5:       return 8'($urandom_range(8'hff, 8'hf8));
      default: return 8'($urandom);
    endcase
  endfunction

  // Half the positions land next to the gap, as real editing does.
  function automatic int unsigned pick_pos(int unsigned lim);
    int p;
    if ($urandom_range(1) == 1) return $urandom_range(lim);
    p = int'(g_lo) + int'($urandom_range(8)) - 4;
    if (p < 0) p = 0;
    if (p > int'(lim)) p = lim;
    return p;
  endfunction

  // Queue one item and return once it has been accepted and modeled.
  task automatic push_edit(kind_e k, int unsigned p, logic [7:0] c);
    edit_q.push_back('{kind: k, pos: POS_W'(p), ch: c});
    while (edit_q.size() != 0) @(negedge clk_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin : drive
      logic took;
      took = in_valid_i && in_ready_o;
      if (took) begin
        edit_buffer(edit_q.pop_front());
      end
      if (!in_valid_i || took) begin
        if (edit_q.size() != 0 && (calm || $urandom_range(99) >= 30)) begin
          in_valid_i <= 1'b1;
          kind_i     <= edit_q[0].kind;
          position_i <= edit_q[0].pos;
          char_in_i  <= edit_q[0].ch;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin : watch
      answer_t want;
      out_ready_i <= calm || ($urandom_range(99) >= 30);
      if (out_valid_o && out_ready_i) begin
        if (answer_q.size() == 0) begin
          flag_mismatch("result with no item pending", 0, 0);
        end else begin
          want = answer_q.pop_front();
          if (new_position_o !== want.new_pos)
            flag_mismatch("new_position", new_position_o, want.new_pos);
          if (read_byte_o !== want.rd) flag_mismatch("read_byte", read_byte_o, want.rd);
          if (status_o !== want.st) flag_mismatch("status", status_o, want.st);
          if (text_length_o !== want.len)
            flag_mismatch("text_length", text_length_o, want.len);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("gap_buffer_text_store test failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int r;
    int s;
    int unsigned ins;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty store and out-of-range cases
    push_edit(KIND_READ, 0, 8'h00);
    push_edit(KIND_DELETE, 0, 8'h00);
    push_edit(KIND_INSERT, 1, 8'h41);
    push_edit(KIND_NOP, 8191, 8'hff);
    // codepoints of one, two and three bytes and a four-byte lead, then a front insert and bad leads
    push_edit(KIND_INSERT, 0, 8'h41);
    push_edit(KIND_INSERT, 1, 8'hc3);
    push_edit(KIND_INSERT, 2, 8'ha9);
    push_edit(KIND_INSERT, 3, 8'he2);
    push_edit(KIND_INSERT, 4, 8'h82);
    push_edit(KIND_INSERT, 5, 8'hac);
    push_edit(KIND_INSERT, 6, 8'hf0);
    push_edit(KIND_INSERT, 0, 8'h00);
    push_edit(KIND_INSERT, 8, 8'hff);
    push_edit(KIND_INSERT, 9, 8'hf8);
    push_edit(KIND_READ, 0, 8'h00);
    push_edit(KIND_READ, 9, 8'h00);
    push_edit(KIND_READ, 10, 8'h00);
    push_edit(KIND_DELETE, 2, 8'h00);
    push_edit(KIND_DELETE, 2, 8'h00);
    push_edit(KIND_DELETE, 4, 8'h00);
    // four-byte lead with only two bytes left: clamped
    push_edit(KIND_DELETE, 2, 8'h00);
    push_edit(KIND_INSERT, 2, 8'h80);
    push_edit(KIND_DELETE, 2, 8'h00);
    push_edit(KIND_DELETE, 2, 8'h00);
    push_edit(KIND_DELETE, 0, 8'h00);
    push_edit(KIND_DELETE, 0, 8'h00);

    for (int i = 0; i < RAND_ITEMS; i++) begin
      calm = (i >= 350 && i < 500);
      r = $urandom_range(99);
      ins = (n_text < 8) ? 70 : (n_text > 160) ? 25 : 48;
      if (r < 5) begin
        push_edit(kind_e'($urandom_range(3)), $urandom_range(8191), 8'($urandom));
      end else if (r < 7) begin
        push_edit(KIND_NOP, pick_pos(n_text), pick_char());
      end else if (r < 10) begin
        push_edit(r[0] ? KIND_READ : KIND_DELETE, n_text, pick_char());
      end else begin
        s = $urandom_range(99);
        if (s < ins) push_edit(KIND_INSERT, pick_pos(n_text), pick_char());
        else if (n_text == 0) push_edit(KIND_DELETE, 0, pick_char());
        else if (s < ins + (100 - ins) / 2)
          push_edit(KIND_DELETE, pick_pos(n_text - 1), pick_char());
        else push_edit(KIND_READ, pick_pos(n_text - 1), pick_char());
      end
    end
    calm = 1'b0;

    // edge positions, then a few mixed edits
    push_edit(KIND_INSERT, n_text, 8'h41);
    push_edit(KIND_INSERT, 8191, 8'h41);
    push_edit(KIND_INSERT, 0, 8'h41);
    push_edit(KIND_READ, n_text - 1, 8'h00);
    push_edit(KIND_READ, 0, 8'h00);
    push_edit(KIND_READ, 4095, 8'h00);
    push_edit(KIND_DELETE, 2000, 8'h00);
    push_edit(KIND_INSERT, 0, 8'h7f);
    push_edit(KIND_INSERT, 0, 8'h80);
    for (int i = 0; i < 8; i++) begin
      push_edit(KIND_DELETE, $urandom_range(n_text - 1), 8'h00);
      push_edit(KIND_INSERT, $urandom_range(n_text), pick_char());
      push_edit(KIND_READ, $urandom_range(n_text - 1), 8'h00);
    end

    while (answer_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("gap_buffer_text_store test passed");
    end else begin
      $display("gap_buffer_text_store test failed");
    end
    $finish;
  end

endmodule
